>>> hdl/permutation_rank_encoder_core_defines.svh
// Assertion macros used by the checker file of the permutation rank encoder.
// No dependencies; included by the file that holds concurrent assertions.
`ifndef PERMUTATION_RANK_ENCODER_CORE_DEFINES_SVH
`define PERMUTATION_RANK_ENCODER_CORE_DEFINES_SVH

// Checked on every rising edge, quiet while reset is high.
`define PERMRK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PERMRK_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/permrk_pkg.sv
// Widths and constants of the permutation rank encoder.
// No dependencies; used by the core and by its checker.
package permrk_pkg;

   localparam int ELEM_W     = 5;
   localparam int SIZE_W     = 5;
   localparam int RANK_W     = 45;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

   // Status codes carried on the result tuser.
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

endpackage

>>> hdl/permutation_rank_encoder_core.sv
// Permutation rank encoder: Lehmer-code ranking of a streamed permutation.
// Depends on permrk_pkg.
// Usage:
//   Elements of a permutation of 1..n arrive one per beat on the req_ channel
//   (req_tdata[4:0]). After the n-th element one result beat leaves on the
//   rsp_ channel: the zero-based lexicographic rank in rsp_tdata[44:0] and the
//   status in rsp_tuser (0 ok, 1 a value out of range or repeated, rank then 0).
//   n is set by writing csr_wdata with csr_we high while the block is idle;
//   a write also discards any permutation in progress. 0 acts as 1 and values
//   above MAX_SIZE act as MAX_SIZE.
// Timing:
//   One beat is accepted every cycle unless a held result stalls a finishing
//   element. A beat is captured in an input register, then the digit search,
//   mask update and rank multiply-add run combinationally into the state and
//   result registers. The 45 by 5 bit multiply-add sets the path.
// Reset and stalls:
//   Synchronous reset empties both registers, sets n to 16 and clears the
//   permutation state. While a result waits on rsp_tready, elements that do
//   not finish a permutation keep flowing; the one that would finish the next
//   permutation waits in the input register and req_tready drops.
module permutation_rank_encoder_core
   import permrk_pkg::*;
#(
   parameter int MAX_SIZE = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [SIZE_W-1:0]     csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [4:0] element, [7:5] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [44:0] rank, [47:45] zero
   output logic                  rsp_tuser    // [0] status
);

   localparam int DIGIT_W = $clog2(MAX_SIZE + 1);
   localparam logic [SIZE_W-1:0] MAX_SIZE_L = SIZE_W'(MAX_SIZE);

   logic [SIZE_W-1:0]   perm_size_ff;
   logic [MAX_SIZE-1:0] mask_ff, mask_in;
   logic [RANK_W-1:0]   rank_ff, rank_in;
   logic [SIZE_W-1:0]   pos_ff, pos_in;
   logic                err_ff, err_in;
   logic                in_vld_ff, in_vld_in;
   logic [ELEM_W-1:0]   in_elem_ff;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [RANK_W-1:0]   rsp_rank_ff;
   logic                rsp_status_ff;

   logic [SIZE_W-1:0]         size_eff;
   logic [MAX_SIZE-1:0]       sel_vec;
   logic [DIGIT_W-1:0]        digit;
   logic                      elem_ok;
   logic [SIZE_W-1:0]         pos_inc;
   logic [SIZE_W-1:0]         weight;
   logic [RANK_W+SIZE_W-1:0]  product;
   logic [RANK_W-1:0]         rank_next;
   logic                      err_next;
   logic                      s1_last;
   logic                      s1_fire;

   always_comb begin
      if (perm_size_ff == '0) begin
         size_eff = SIZE_W'(1);
      end else if (perm_size_ff > MAX_SIZE_L) begin
         size_eff = MAX_SIZE_L;
      end else begin
         size_eff = perm_size_ff;
      end
   end

   // Digit = number of still unused values below the element.
   always_comb begin
      digit = '0;
      for (int i = 0; i < MAX_SIZE; i++) begin
         sel_vec[i] = (in_elem_ff == ELEM_W'(i + 1));
         if ((ELEM_W'(i + 1) < in_elem_ff) && mask_ff[i]) begin
            digit = digit + DIGIT_W'(1);
         end
      end
   end

   assign elem_ok = (in_elem_ff != '0) && (in_elem_ff <= size_eff) && (|(sel_vec & mask_ff));

   assign pos_inc   = pos_ff + SIZE_W'(1);
   assign s1_last   = (pos_inc >= size_eff);
   assign weight    = (pos_ff < size_eff) ? (size_eff - pos_ff) : SIZE_W'(1);
   assign product   = {{SIZE_W{1'b0}}, rank_ff} * {{RANK_W{1'b0}}, weight};
   assign rank_next = product[RANK_W-1:0] + (elem_ok ? RANK_W'(digit) : '0);
   assign err_next  = err_ff | ~elem_ok;

   // The finishing element waits only when the result register is still held.
   assign s1_fire    = in_vld_ff && (!s1_last || !rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || s1_fire;

   always_comb begin
      mask_in = mask_ff;
      rank_in = rank_ff;
      pos_in  = pos_ff;
      err_in  = err_ff;
      if (csr_we) begin
         mask_in = '1;
         rank_in = '0;
         pos_in  = '0;
         err_in  = 1'b0;
      end else if (s1_fire) begin
         if (s1_last) begin
            mask_in = '1;
            rank_in = '0;
            pos_in  = '0;
            err_in  = 1'b0;
         end else begin
            mask_in = elem_ok ? (mask_ff & ~sel_vec) : mask_ff;
            rank_in = rank_next;
            pos_in  = pos_inc;
            err_in  = err_next;
         end
      end
   end

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in = 1'b1;
      end else if (s1_fire) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (s1_fire && s1_last) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         perm_size_ff <= SIZE_RESET;
         mask_ff      <= '1;
         rank_ff      <= '0;
         pos_ff       <= '0;
         err_ff       <= 1'b0;
         in_vld_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            perm_size_ff <= csr_wdata;
         end
         mask_ff    <= mask_in;
         rank_ff    <= rank_in;
         pos_ff     <= pos_in;
         err_ff     <= err_in;
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_elem_ff <= req_tdata[ELEM_W-1:0];
      end
      if (s1_fire && s1_last) begin
         rsp_rank_ff   <= err_next ? '0 : rank_next;
         rsp_status_ff <= err_next ? STATUS_ERR : STATUS_OK;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RANK_W){1'b0}}, rsp_rank_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

>>> hdl/permrk_checker.sv
// Port-level checks of the permutation rank encoder, bound to the top level.
// Depends on permrk_pkg and permutation_rank_encoder_core_defines.svh.
`include "permutation_rank_encoder_core_defines.svh"

module permrk_checker
   import permrk_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // A held result beat keeps its payload until it is taken.
   `PERMRK_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)), "result beat changed while stalled")

   `PERMRK_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, $past(reset) |-> !rsp_tvalid, "result valid straight after reset")

   // A permutation with a bad element reports a zero rank.
   `PERMRK_ASSERT(a_err_rank_zero, clock, reset, (rsp_tvalid && (rsp_tuser == STATUS_ERR)) |-> (rsp_tdata == '0), "non-zero rank with error status")

   `PERMRK_ASSERT(a_pad_zero, clock, reset, rsp_tvalid |-> (rsp_tdata[RSP_DATA_W-1:RANK_W] == '0), "padding bits of result data set")

endmodule

bind permutation_rank_encoder_core permrk_checker u_permrk_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
